### hw/rtl/egaq_pkg.sv
// Shared types, constants and palette functions for the EGA 16-color quantizer.
// Used by egaq_cell, egaq_pack and ega16_quantize_planar_pack. No dependencies.

package egaq_pkg;

	localparam int CHAN_W     = 8;
	localparam int NUM_COLORS = 16;
	localparam int IDX_W      = $clog2(NUM_COLORS);
	localparam int NUM_PLANES = 4;
	localparam int POS_W      = 3;
	// 3 * 255^2 = 195075 fits in 18 bits; all ones is above any real distance
	localparam int DIST_W     = 18;
	localparam int IN_W       = 3 * CHAN_W;
	localparam int OUT_W      = NUM_PLANES * CHAN_W;

	localparam logic [POS_W-1:0]  LAST_POS  = 3'd7;
	localparam logic [CHAN_W-1:0] FIRST_BIT = 8'h80;

	typedef struct packed {
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] red;
	} rgb_t;

	// Token that walks down the cell chain: pixel plus best match so far
	typedef struct packed {
		rgb_t              pix;
		logic [DIST_W-1:0] score;
		logic [IDX_W-1:0]  idx;
	} tok_t;

	function automatic rgb_t palette_rgb(input logic [IDX_W-1:0] idx);
		rgb_t c;
		unique case (idx)
			4'd0:    c = '{blue: 8'd0,   green: 8'd0,   red: 8'd0};
			4'd1:    c = '{blue: 8'd170, green: 8'd0,   red: 8'd0};
			4'd2:    c = '{blue: 8'd0,   green: 8'd170, red: 8'd0};
			4'd3:    c = '{blue: 8'd170, green: 8'd170, red: 8'd0};
			4'd4:    c = '{blue: 8'd0,   green: 8'd0,   red: 8'd170};
			4'd5:    c = '{blue: 8'd170, green: 8'd0,   red: 8'd170};
			4'd6:    c = '{blue: 8'd0,   green: 8'd85,  red: 8'd170};
			4'd7:    c = '{blue: 8'd170, green: 8'd170, red: 8'd170};
			4'd8:    c = '{blue: 8'd85,  green: 8'd85,  red: 8'd85};
			4'd9:    c = '{blue: 8'd255, green: 8'd85,  red: 8'd85};
			4'd10:   c = '{blue: 8'd85,  green: 8'd255, red: 8'd85};
			4'd11:   c = '{blue: 8'd255, green: 8'd255, red: 8'd85};
			4'd12:   c = '{blue: 8'd85,  green: 8'd85,  red: 8'd255};
			4'd13:   c = '{blue: 8'd255, green: 8'd85,  red: 8'd255};
			4'd14:   c = '{blue: 8'd85,  green: 8'd255, red: 8'd255};
			default: c = '{blue: 8'd255, green: 8'd255, red: 8'd255};
		endcase
		return c;
	endfunction

	function automatic logic [2*CHAN_W-1:0] chan_sq(input logic [CHAN_W-1:0] a,
			input logic [CHAN_W-1:0] b);
		logic [CHAN_W-1:0] d;
		d = (a >= b) ? (a - b) : (b - a);
		return (2*CHAN_W)'(d) * (2*CHAN_W)'(d);
	endfunction

	function automatic logic [DIST_W-1:0] sq_dist(input rgb_t a, input rgb_t b);
		return DIST_W'(chan_sq(a.red, b.red)) + DIST_W'(chan_sq(a.green, b.green))
			+ DIST_W'(chan_sq(a.blue, b.blue));
	endfunction

endpackage

### hw/rtl/egaq_cell.sv
// One palette cell of the quantizer chain: scores the pixel against one color.
// Depends on egaq_pkg.

module egaq_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [egaq_pkg::IDX_W-1:0]  cell_idx,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  egaq_pkg::tok_t              in_tok,
	output logic                        out_valid,
	input  logic                        out_ready,
	output egaq_pkg::tok_t              out_tok
);
	import egaq_pkg::*;

	logic              valid_q;
	tok_t              tok_q;
	logic [DIST_W-1:0] cand_score;
	tok_t              tok_next;

	assign in_ready = !valid_q || out_ready;

	always_comb begin
		cand_score = sq_dist(in_tok.pix, palette_rgb(cell_idx));
		tok_next   = in_tok;
		// strict compare keeps the lower index on a tie
		if (cand_score < in_tok.score) begin
			tok_next.score = cand_score;
			tok_next.idx   = cell_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			tok_q <= tok_next;
		end
	end

	assign out_valid = valid_q;
	assign out_tok   = tok_q;

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !out_ready |=> valid_q && $stable(tok_q))
		else $error("cell dropped or changed a stalled word");

	a_best_not_worse: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> tok_q.score <= $past(in_tok.score))
		else $error("cell raised the best distance");

	a_scored: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> tok_q.score != '1)
		else $error("word left the cell without a real distance");

endmodule

### hw/rtl/egaq_pack.sv
// Planar packer: collects index bits of eight pixels into four plane bytes.
// Holds the output register of the block. Depends on egaq_pkg.

module egaq_pack (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [egaq_pkg::IDX_W-1:0]         in_idx,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [egaq_pkg::NUM_PLANES-1:0][egaq_pkg::CHAN_W-1:0] out_planes
);
	import egaq_pkg::*;

	logic [POS_W-1:0]                        pos_q;
	logic [NUM_PLANES-1:0][CHAN_W-1:0]       acc_q;
	logic [NUM_PLANES-1:0][CHAN_W-1:0]       acc_next;
	logic [NUM_PLANES-1:0][CHAN_W-1:0]       planes_q;
	logic                                    out_valid_q;
	logic [CHAN_W-1:0]                       mask;
	logic                                    take;
	logic                                    flush;

	// only the eighth pixel needs the output register
	assign in_ready = (pos_q != LAST_POS) || !out_valid_q || out_ready;
	assign take     = in_valid && in_ready;
	assign flush    = take && (pos_q == LAST_POS);
	assign mask     = FIRST_BIT >> pos_q;

	always_comb begin
		for (int p = 0; p < NUM_PLANES; p++) begin
			acc_next[p] = acc_q[p] | (in_idx[p] ? mask : '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				pos_q <= pos_q + 1'b1;
				acc_q <= flush ? '0 : acc_next;
			end
			if (flush) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (flush) begin
			planes_q <= acc_next;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_planes = planes_q;

	a_clear_after_flush: assert property (@(posedge clk) disable iff (!arst_n)
		flush |=> (pos_q == '0) && (acc_q == '0))
		else $error("accumulators not cleared after a full group");

	a_unfilled_bits_zero: assert property (@(posedge clk) disable iff (!arst_n)
		((acc_q[0] | acc_q[1] | acc_q[2] | acc_q[3]) & (8'hFF >> pos_q)) == 8'h00)
		else $error("bit set at a position not yet filled");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !flush)
		else $error("pending result overwritten");

endmodule

### hw/rtl/ega16_quantize_planar_pack.sv
// Top level: 16-cell nearest-color chain followed by the planar packer.
// Depends on egaq_pkg, egaq_cell and egaq_pack.
//
//  channel | dir | word contents
//  s_*     | in  | one RGB pixel, 24 bits
//  m_*     | out | four plane bytes after every eighth pixel, 32 bits
//
// Takes one pixel per clock unless stalled; each of the 16 cells
// scores one palette color and hands pixel and best match to the next cell.
// A group's 8th pixel crosses 16 cell registers and the packer output register.
// arst_n clears all valid bits, the pixel position and the plane accumulators.
// Ready ripples back stage by stage; bubbles fill in, and pixels that do not
// close a group keep flowing while a result waits on m_tready.

module ega16_quantize_planar_pack (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [egaq_pkg::IN_W-1:0]  s_tdata,  // red[7:0], green[15:8], blue[23:16]
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [egaq_pkg::OUT_W-1:0] m_tdata   // plane0..plane3_byte, 8 bits each
);
	import egaq_pkg::*;

	tok_t chain_tok   [NUM_COLORS+1];
	logic chain_valid [NUM_COLORS+1];
	logic chain_ready [NUM_COLORS+1];

	assign chain_valid[0]     = s_tvalid;
	assign s_tready           = chain_ready[0];
	assign chain_tok[0].pix   = rgb_t'(s_tdata);
	assign chain_tok[0].score = '1;
	assign chain_tok[0].idx   = '0;

	for (genvar i = 0; i < NUM_COLORS; i++) begin : g_cell
		egaq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cell_idx  (IDX_W'(i)),
			.in_valid  (chain_valid[i]),
			.in_ready  (chain_ready[i]),
			.in_tok    (chain_tok[i]),
			.out_valid (chain_valid[i+1]),
			.out_ready (chain_ready[i+1]),
			.out_tok   (chain_tok[i+1])
		);
	end

	egaq_pack u_pack (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (chain_valid[NUM_COLORS]),
		.in_ready   (chain_ready[NUM_COLORS]),
		.in_idx     (chain_tok[NUM_COLORS].idx),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_planes (m_tdata)
	);

endmodule
